// File: hdl/lprl_pkg.sv
// shared types and constants of the longest prefix route lookup
package lprl_pkg;

    // command codes
    localparam logic [1:0] CMD_WRITE      = 2'd0;
    localparam logic [1:0] CMD_INVALIDATE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP     = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  entry_index;
        logic [31:0] entry_prefix;
        logic [31:0] entry_mask;
        logic [31:0] entry_gateway;
        logic [3:0]  entry_port;
        logic [31:0] lookup_address;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [31:0] next_hop;
        logic [3:0]  out_port;
        logic [31:0] matched_mask;
    } t_out_item;

    // one routing table row
    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [3:0]  port;
    } t_entry;

    // verdict of the compare unit for one row
    typedef struct packed {
        logic matched;
        logic take;
    } t_match;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_FIN
    } t_state;

endpackage

// File: hdl/lprl_match.sv
// shared compare unit: prefix match under mask and best-mask compare
module lprl_match (
    input  lprl_pkg::t_entry i_entry,
    input  logic             i_entry_valid,
    input  logic [31:0]      i_addr,
    input  logic             i_hit,
    input  logic [31:0]      i_best_mask,
    output lprl_pkg::t_match o_res
);

    logic w_matched;
    logic w_longer;

    assign w_matched = i_entry_valid &&
                       (((i_entry.prefix ^ i_addr) & i_entry.mask) == 32'd0);
    // strictly greater keeps the lowest index on ties
    assign w_longer  = !i_hit || (i_entry.mask > i_best_mask);

    assign o_res.matched = w_matched;
    assign o_res.take    = w_matched && w_longer;

endmodule

// File: hdl/longest_prefix_route_lookup_unit.sv
// top level of the longest prefix route lookup
// A routing table of TABLE_ENTRIES rows (prefix, mask, gateway, port, valid) takes three
// commands on the input channel. A write or an invalidate gives no result, and the block is
// ready again on the next cycle. A lookup walks the table one row per cycle through the
// single read port of the table memory and one shared compare unit, so it holds the input
// stalled while it reads every row, judges the last row and hands the result to the output
// register, and for as long as the output side stalls a previous result. The result is the
// valid row with the numerically greatest mask whose prefix equals the address under that
// mask, lowest index on ties; a zero mask is a default route. With no match all result
// fields are zero. Rows start out invalid after reset and need no clearing pass; slots at or
// beyond TABLE_ENTRIES and the unused command code are ignored.
module longest_prefix_route_lookup_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lprl_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lprl_pkg::t_out_item o_out_data
);

    // row index width; a one-row table still gets one bit
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [8:0] DEPTH = 9'(TABLE_ENTRIES);

    // table memory and per-row valid flags
    lprl_pkg::t_entry r_table [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    // sequencer
    lprl_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;

    // read stage
    lprl_pkg::t_entry r_rd_entry;
    logic             r_rd_ent_valid;
    logic             r_rd_vld;

    // running best match
    logic             r_hit;
    logic [31:0]      r_best_mask;
    logic [31:0]      r_best_gw;
    logic [3:0]       r_best_port;
    logic [31:0]      r_addr;

    // output register
    logic                r_out_valid;
    lprl_pkg::t_out_item r_out_data;

    logic             w_in_acc;
    logic             w_slot_ok;
    logic [IDX_W-1:0] w_wr_idx;
    logic             w_do_write;
    logic             w_do_inval;
    logic             w_do_lookup;
    logic             w_load_out;
    lprl_pkg::t_match w_match;

    assign o_in_stall  = (r_state != lprl_pkg::ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_slot_ok   = ({5'd0, i_in_data.entry_index} < DEPTH);
    assign w_wr_idx    = IDX_W'(i_in_data.entry_index);
    assign w_do_write  = w_in_acc && (i_in_data.command == lprl_pkg::CMD_WRITE) && w_slot_ok;
    assign w_do_inval  = w_in_acc && (i_in_data.command == lprl_pkg::CMD_INVALIDATE) &&
                         w_slot_ok;
    assign w_do_lookup = w_in_acc && (i_in_data.command == lprl_pkg::CMD_LOOKUP);

    // table write port and registered read port
    always_ff @(posedge i_clk) begin
        if (w_do_write) begin
            r_table[w_wr_idx] <= '{prefix:  i_in_data.entry_prefix,
                                   mask:    i_in_data.entry_mask,
                                   gateway: i_in_data.entry_gateway,
                                   port:    i_in_data.entry_port};
        end
        r_rd_entry     <= r_table[r_cnt];
        r_rd_ent_valid <= r_valid[r_cnt];
    end

    // valid flags, cleared at reset so never-written rows cannot match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_do_write) begin
            r_valid[w_wr_idx] <= 1'b1;
        end else if (w_do_inval) begin
            r_valid[w_wr_idx] <= 1'b0;
        end
    end

    // the one compare unit, fed one row per cycle
    lprl_match u_match (
        .i_entry       (r_rd_entry),
        .i_entry_valid (r_rd_ent_valid),
        .i_addr        (r_addr),
        .i_hit         (r_hit),
        .i_best_mask   (r_best_mask),
        .o_res         (w_match)
    );

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        w_load_out = 1'b0;
        unique case (r_state)
            lprl_pkg::ST_IDLE: begin
                if (w_do_lookup) begin
                    n_state = lprl_pkg::ST_SCAN;
                    n_cnt   = '0;
                end
            end
            lprl_pkg::ST_SCAN: begin
                // issue one table read per cycle
                n_cnt = IDX_W'(r_cnt + 1'b1);
                if (r_cnt == LAST_IDX) begin
                    n_state = lprl_pkg::ST_TAIL;
                end
            end
            lprl_pkg::ST_TAIL: begin
                // last row is judged in this cycle
                n_state = lprl_pkg::ST_FIN;
            end
            lprl_pkg::ST_FIN: begin
                // wait until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = lprl_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lprl_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= (r_state == lprl_pkg::ST_SCAN);
            if (w_do_lookup) begin
                r_hit <= 1'b0;
            end else if (r_rd_vld && w_match.take) begin
                r_hit <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // best-match payload and lookup address
    always_ff @(posedge i_clk) begin
        if (w_do_lookup) begin
            r_addr <= i_in_data.lookup_address;
        end
        if (r_rd_vld && w_match.take) begin
            r_best_mask <= r_rd_entry.mask;
            r_best_gw   <= r_rd_entry.gateway;
            r_best_port <= r_rd_entry.port;
        end
        if (w_load_out) begin
            r_out_data.found        <= r_hit;
            r_out_data.next_hop     <= r_hit ? r_best_gw : 32'd0;
            r_out_data.out_port     <= r_hit ? r_best_port : 4'd0;
            r_out_data.matched_mask <= r_hit ? r_best_mask : 32'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: hdl/lprl_checker.sv
// port-level checks of the route lookup and their bind to the top level
module lprl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input lprl_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lprl_pkg::t_out_item o_out_data
);

    // a stalled result item stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result item changed while stalled");

    // an accepted lookup occupies the block on the next cycle
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.command == lprl_pkg::CMD_LOOKUP))
        |=> o_in_stall)
        else $error("lookup accepted but block not busy");

    // table updates and unused codes leave the block ready
    a_update_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.command != lprl_pkg::CMD_LOOKUP))
        |=> !o_in_stall)
        else $error("block busy after a non-lookup item");

    // a miss reports all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |->
        ((o_out_data.next_hop == 32'd0) && (o_out_data.out_port == 4'd0) &&
         (o_out_data.matched_mask == 32'd0)))
        else $error("miss with nonzero result fields");

endmodule

bind longest_prefix_route_lookup_unit lprl_checker u_lprl_checker (.*);

// File: bench/tb_longest_prefix_route_lookup_unit.sv
// testbench of the longest prefix route lookup: table writes, invalidates and lookups checked
module tb_longest_prefix_route_lookup_unit;

    localparam int TABLE_ENTRIES = 16;
    // items to queue in the random part, every command code counted
    localparam int RANDOM_ITEMS  = 1350;
    // a lookup holds the input for a whole table scan, stalls and gaps come on top
    localparam int CYCLE_LIMIT   = 400000;
    // window where the driver never idles and the output side never stalls
    localparam int QUIET_FROM    = 4000;
    localparam int QUIET_TO      = 7000;
    localparam int DRAIN_CYCLES  = 2 * TABLE_ENTRIES + 8;
    // the one command code the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    lprl_pkg::t_in_item  in_data   = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    lprl_pkg::t_out_item out_data;

    int        cycle_count    = 0;
    int        mismatch_count = 0;

    // commands waiting to be driven, and lookup results still owed by the block
    lprl_pkg::t_in_item  route_cmds[$];
    lprl_pkg::t_out_item expected_routes[$];

    // routing table as the checker sees it, updated on every accepted item
    logic [31:0] rt_prefix  [TABLE_ENTRIES];
    logic [31:0] rt_mask    [TABLE_ENTRIES];
    logic [31:0] rt_gateway [TABLE_ENTRIES];
    logic [3:0]  rt_port    [TABLE_ENTRIES];
    logic        rt_valid   [TABLE_ENTRIES];

    // table as the stimulus generator sees it, so lookups can aim at live routes
    logic [31:0] gen_prefix [TABLE_ENTRIES];
    logic [31:0] gen_mask   [TABLE_ENTRIES];
    logic        gen_live   [TABLE_ENTRIES];

    longest_prefix_route_lookup_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // contiguous network mask of the given length, 0 gives the default route mask
    function automatic logic [31:0] prefix_mask(input int len);
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    // about a third of the cycles idle, except inside the quiet window
    function automatic logic draw_idle();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 33;
    endfunction

    // best route for an address: greatest mask among matching valid rows, lowest index on ties
    function automatic lprl_pkg::t_out_item predict_route(input logic [31:0] addr);
        lprl_pkg::t_out_item best;
        best = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (rt_valid[i] && ((rt_prefix[i] & rt_mask[i]) == (addr & rt_mask[i]))
                    && (!best.found || rt_mask[i] > best.matched_mask)) begin
                best.found        = 1'b1;
                best.next_hop     = rt_gateway[i];
                best.out_port     = rt_port[i];
                best.matched_mask = rt_mask[i];
            end
        end
        return best;
    endfunction

    // apply one accepted item to the table and record the owed result of a lookup
    task automatic commit_command(input lprl_pkg::t_in_item it);
        case (it.command)
            lprl_pkg::CMD_WRITE: begin
                rt_prefix[it.entry_index]  = it.entry_prefix;
                rt_mask[it.entry_index]    = it.entry_mask;
                rt_gateway[it.entry_index] = it.entry_gateway;
                rt_port[it.entry_index]    = it.entry_port;
                rt_valid[it.entry_index]   = 1'b1;
            end
            lprl_pkg::CMD_INVALIDATE: begin
                rt_valid[it.entry_index] = 1'b0;
            end
            lprl_pkg::CMD_LOOKUP: begin
                expected_routes.push_back(predict_route(it.lookup_address));
            end
            default: begin
                // unused code: no effect
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // queue one item and keep the generator's view of the table in step
    task automatic queue_cmd(input logic [1:0] cmd, input logic [3:0] idx,
                             input logic [31:0] pfx, input logic [31:0] msk,
                             input logic [31:0] gw, input logic [3:0] prt,
                             input logic [31:0] addr);
        lprl_pkg::t_in_item it;
        it.command        = cmd;
        it.entry_index    = idx;
        it.entry_prefix   = pfx;
        it.entry_mask     = msk;
        it.entry_gateway  = gw;
        it.entry_port     = prt;
        it.lookup_address = addr;
        route_cmds.push_back(it);
        if (cmd == lprl_pkg::CMD_WRITE) begin
            gen_prefix[idx] = pfx;
            gen_mask[idx]   = msk;
            gen_live[idx]   = 1'b1;
        end else if (cmd == lprl_pkg::CMD_INVALIDATE) begin
            gen_live[idx] = 1'b0;
        end
    endtask

    // cycle counter and run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items unsent, %0d results owed", $time,
                     route_cmds.size(), expected_routes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // driver: a new item is presented only once the current one is taken, so a
    // stalled payload holds still
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (route_cmds.size() != 0 && !draw_idle()) begin
                in_data  <= route_cmds.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output side back-pressure
    always @(posedge i_clk) begin
        out_stall <= draw_idle();
    end

    // monitor: results are checked against the oldest owed lookup, then accepted inputs
    // update the table copy
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_routes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, out_data);
                    mismatch_count++;
                end else begin
                    lprl_pkg::t_out_item want;
                    want = expected_routes.pop_front();
                    check_field("found", 32'(want.found), 32'(out_data.found));
                    check_field("next_hop", want.next_hop, out_data.next_hop);
                    check_field("out_port", 32'(want.out_port), 32'(out_data.out_port));
                    check_field("matched_mask", want.matched_mask, out_data.matched_mask);
                end
            end
            if (in_valid && !in_stall)
                commit_command(in_data);
        end
    end

    initial begin : stimulus
        int          issued;
        int          pick;
        int          sel;
        logic [3:0]  idx;
        logic [31:0] msk;
        logic [31:0] addr;

        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            rt_valid[i] = 1'b0;
            gen_live[i] = 1'b0;
        end

        // directed part
        // lookup on an empty table
        queue_cmd(lprl_pkg::CMD_LOOKUP, 4'($urandom), $urandom, $urandom, $urandom,
                  4'($urandom), 32'h0);
        // default route in the lowest slot
        queue_cmd(lprl_pkg::CMD_WRITE, 4'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'hF, $urandom);
        queue_cmd(lprl_pkg::CMD_LOOKUP, 4'($urandom), $urandom, $urandom, $urandom,
                  4'($urandom), 32'hFFFF_FFFF);
        // host route in the highest slot beats the default
        queue_cmd(lprl_pkg::CMD_WRITE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h0,
                  $urandom);
        queue_cmd(lprl_pkg::CMD_LOOKUP, 4'($urandom), $urandom, $urandom, $urandom,
                  4'($urandom), 32'hFFFF_FFFF);
        // two /8 routes with equal masks, prefix bits set outside the mask
        queue_cmd(lprl_pkg::CMD_WRITE, 4'd3, 32'h0A00_00FF, 32'hFF00_0000, 32'h0A00_0001,
                  4'd3, $urandom);
        queue_cmd(lprl_pkg::CMD_WRITE, 4'd5, 32'h0A12_3456, 32'hFF00_0000, 32'h0A00_0002,
                  4'd5, $urandom);
        queue_cmd(lprl_pkg::CMD_LOOKUP, 4'($urandom), $urandom, $urandom, $urandom,
                  4'($urandom), 32'h0A99_8877);
        // longer match in a higher slot
        queue_cmd(lprl_pkg::CMD_WRITE, 4'd7, 32'h0A12_0000, 32'hFFFF_0000, 32'h0A12_0001,
                  4'd7, $urandom);
        queue_cmd(lprl_pkg::CMD_LOOKUP, 4'($urandom), $urandom, $urandom, $urandom,
                  4'($urandom), 32'h0A12_ABCD);
        // drop the tie winner, the other /8 takes over
        queue_cmd(lprl_pkg::CMD_INVALIDATE, 4'd3, $urandom, $urandom, $urandom,
                  4'($urandom), $urandom);
        queue_cmd(lprl_pkg::CMD_LOOKUP, 4'($urandom), $urandom, $urandom, $urandom,
                  4'($urandom), 32'h0A99_8877);
        // unused code aimed at a live slot must change nothing
        queue_cmd(CMD_UNUSED, 4'd5, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0A99_8877);
        queue_cmd(lprl_pkg::CMD_LOOKUP, 4'($urandom), $urandom, $urandom, $urandom,
                  4'($urandom), 32'h0A99_8877);
        // without the default route nothing matches
        queue_cmd(lprl_pkg::CMD_INVALIDATE, 4'd0, $urandom, $urandom, $urandom,
                  4'($urandom), $urandom);
        queue_cmd(lprl_pkg::CMD_LOOKUP, 4'($urandom), $urandom, $urandom, $urandom,
                  4'($urandom), 32'h5555_5555);
        // invalidate a slot that was never written
        queue_cmd(lprl_pkg::CMD_INVALIDATE, 4'd9, $urandom, $urandom, $urandom,
                  4'($urandom), $urandom);
        // non-contiguous mask
        queue_cmd(lprl_pkg::CMD_WRITE, 4'd0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                  4'd9, $urandom);
        queue_cmd(lprl_pkg::CMD_LOOKUP, 4'($urandom), $urandom, $urandom, $urandom,
                  4'($urandom), 32'h5555_5555);
        queue_cmd(lprl_pkg::CMD_LOOKUP, 4'($urandom), $urandom, $urandom, $urandom,
                  4'($urandom), 32'hAAAA_AAAA);

        // random part: mostly lookups aimed at live routes so that masks compete
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            idx  = 4'($urandom_range(0, TABLE_ENTRIES - 1));
            if (pick < 30) begin
                sel = $urandom_range(0, 99);
                if (sel < 65)
                    msk = prefix_mask($urandom_range(0, 32));
                else if (sel < 85)
                    msk = prefix_mask(8 * $urandom_range(1, 3));  // few lengths, many ties
                else
                    msk = $urandom;
                queue_cmd(lprl_pkg::CMD_WRITE, idx, $urandom, msk, $urandom, 4'($urandom),
                          $urandom);
            end else if (pick < 40) begin
                queue_cmd(lprl_pkg::CMD_INVALIDATE, idx, $urandom, $urandom, $urandom,
                          4'($urandom), $urandom);
            end else if (pick < 45) begin
                queue_cmd(CMD_UNUSED, idx, $urandom, $urandom, $urandom, 4'($urandom),
                          $urandom);
            end else begin
                if (gen_live[idx] && $urandom_range(0, 99) < 75)
                    addr = (gen_prefix[idx] & gen_mask[idx]) | ($urandom & ~gen_mask[idx]);
                else
                    addr = $urandom;
                queue_cmd(lprl_pkg::CMD_LOOKUP, 4'($urandom), $urandom, $urandom, $urandom,
                          4'($urandom), addr);
            end
            issued++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sampled on the falling edge so the driver's updates have settled
        while (route_cmds.size() != 0 || in_valid)
            @(negedge i_clk);
        while (expected_routes.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
